### rtl/sirt_pkg.sv
// Package for the signed integer to radix text converter.
// Holds widths, character codes, register indexes, the reciprocal table and
// the request and response structs of the digit divider. No dependencies.
package sirt_pkg;

  localparam int unsigned MagW       = 32;
  localparam int unsigned MaxBaseInt = 16;
  localparam int unsigned DigW       = $clog2(MaxBaseInt);
  localparam int unsigned LenW       = 5;
  localparam int unsigned StackDepth = MagW;
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned Slots      = 16;
  localparam int unsigned SlotW      = $clog2(Slots);

  localparam logic [LenW-1:0] MaxBase = LenW'(MaxBaseInt);
  localparam logic [LenW-1:0] MinBase = LenW'(2);

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [CfgIdxW-1:0] RegBaseLen    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegAlphabetLo = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegAlphabetHi = CfgIdxW'(2);

  typedef struct packed {
    logic            start;
    logic [MagW-1:0] mag;
    logic [LenW-1:0] radix;
  } div_req_t;

  typedef struct packed {
    logic [MagW-1:0] quot;
    logic [DigW-1:0] digit;
  } div_rsp_t;

  // Floor of 2^32 divided by the radix.
  function automatic logic [MagW-1:0] recip(input logic [LenW-1:0] r);
    logic [MagW-1:0] m;
    case (r)
      5'd2:    m = 32'h8000_0000;
      5'd3:    m = 32'h5555_5555;
      5'd4:    m = 32'h4000_0000;
      5'd5:    m = 32'h3333_3333;
      5'd6:    m = 32'h2AAA_AAAA;
      5'd7:    m = 32'h2492_4924;
      5'd8:    m = 32'h2000_0000;
      5'd9:    m = 32'h1C71_C71C;
      5'd10:   m = 32'h1999_9999;
      5'd11:   m = 32'h1745_D174;
      5'd12:   m = 32'h1555_5555;
      5'd13:   m = 32'h13B1_3B13;
      5'd14:   m = 32'h1249_2492;
      5'd15:   m = 32'h1111_1111;
      5'd16:   m = 32'h1000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] alpha_char(input logic [CfgDataW-1:0] lo,
                                            input logic [CfgDataW-1:0] hi,
                                            input logic [SlotW-1:0]    pos);
    logic [CfgDataW-1:0] word;
    word = pos[SlotW-1] ? hi : lo;
    return word[pos[SlotW-2:0]*8 +: 8];
  endfunction

endpackage

### rtl/sirt_if.sv
// Channel interfaces of the signed integer to radix text converter.
// Input number, output character and configuration write channels.
// Depends on sirt_pkg.
interface sirt_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sirt_pkg::MagW-1:0]   value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sirt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

interface sirt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sirt_pkg::CfgIdxW-1:0]     index;
  logic [sirt_pkg::CfgDataW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/sirt_div.sv
// Digit divider: quotient and remainder by the radix from a registered product.
// Multiplies by a reciprocal, then corrects the estimate by one step.
// Depends on sirt_pkg.
module sirt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sirt_pkg::div_req_t req_i,
  output sirt_pkg::div_rsp_t rsp_o
);

  logic [2*sirt_pkg::MagW-1:0] prod_q;
  logic [sirt_pkg::MagW-1:0]   mag_q;
  logic [sirt_pkg::LenW-1:0]   radix_q;
  logic [sirt_pkg::MagW-1:0]   q_est;
  logic [sirt_pkg::MagW-1:0]   rem_est;
  logic [sirt_pkg::MagW-1:0]   radix_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q  <= '0;
      mag_q   <= '0;
      radix_q <= '0;
    end else if (req_i.start) begin
      prod_q  <= (2*sirt_pkg::MagW)'(req_i.mag) *
                 (2*sirt_pkg::MagW)'(sirt_pkg::recip(req_i.radix));
      mag_q   <= req_i.mag;
      radix_q <= req_i.radix;
    end
  end

  always_comb begin
    radix_ext = sirt_pkg::MagW'(radix_q);
    q_est     = prod_q[2*sirt_pkg::MagW-1:sirt_pkg::MagW];
    rem_est   = mag_q - sirt_pkg::MagW'(q_est * radix_ext);
    if (rem_est >= radix_ext) begin
      rsp_o.quot  = q_est + sirt_pkg::MagW'(1);
      rsp_o.digit = sirt_pkg::DigW'(rem_est - radix_ext);
    end else begin
      rsp_o.quot  = q_est;
      rsp_o.digit = sirt_pkg::DigW'(rem_est);
    end
  end

endmodule

### rtl/signed_int_to_radix_text_top.sv
// Top level of the signed integer to radix text converter.
// Holds the configuration registers, the sequencer and the digit stack.
// Depends on sirt_pkg, the channel interfaces and sirt_div.

// One number is accepted only while the block is idle. It first checks the
// alphabet, one character per cycle, then extracts digits through the
// reciprocal divider (states ST_DIV_MUL and ST_DIV_FIX per digit), and then
// sends one character per cycle while the output register is free: the sign
// if negative, then the digits from most significant to least, the final one
// marked by last_char. With an invalid alphabet the number is dropped after
// the check and nothing is sent. The output register lets the next number be
// accepted while the last character still waits.
module signed_int_to_radix_text_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  sirt_in_if.sink         in_i,
  sirt_out_if.source      out_o,
  sirt_cfg_if.sink        cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [sirt_pkg::LenW-1:0]     base_len_q;
  logic [sirt_pkg::CfgDataW-1:0] alpha_lo_q;
  logic [sirt_pkg::CfgDataW-1:0] alpha_hi_q;
  logic                          neg_q, neg_d;
  logic                          sign_pend_q, sign_pend_d;
  logic [sirt_pkg::MagW-1:0]     mag_q, mag_d;
  logic [sirt_pkg::SlotW-1:0]    idx_q, idx_d;
  logic [sirt_pkg::CntW-1:0]     ndig_q, ndig_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    out_char_q, out_char_d;
  logic                          out_last_q, out_last_d;
  logic [sirt_pkg::DigW-1:0]     stack_q [sirt_pkg::StackDepth];

  logic                          push;
  logic                          pop;
  logic                          out_free;
  logic                          len_ok;
  logic                          char_bad;
  logic [7:0]                    cur_char;
  logic [sirt_pkg::SlotW-1:0]    last_idx;
  logic [sirt_pkg::MagW-1:0]     raw;
  sirt_pkg::div_req_t            div_req;
  sirt_pkg::div_rsp_t            div_rsp;

  sirt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_i.ready     = 1'b1;
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.last_char = out_last_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign len_ok   = base_len_q inside {[sirt_pkg::MinBase:sirt_pkg::MaxBase]};
  assign last_idx = sirt_pkg::SlotW'(base_len_q - sirt_pkg::LenW'(1));
  assign raw      = unsigned'(in_i.value);
  assign cur_char = sirt_pkg::alpha_char(alpha_lo_q, alpha_hi_q, idx_q);

  assign div_req.start = (state_q == ST_DIV_MUL);
  assign div_req.mag   = mag_q;
  assign div_req.radix = base_len_q;

  always_comb begin
    char_bad = (cur_char == sirt_pkg::CharNul) || (cur_char == sirt_pkg::CharMinus) ||
               (cur_char == sirt_pkg::CharPlus);
    for (int j = 0; j < sirt_pkg::Slots; j++) begin
      if ((sirt_pkg::LenW'(j) > sirt_pkg::LenW'(idx_q)) &&
          (sirt_pkg::LenW'(j) < base_len_q) &&
          (sirt_pkg::alpha_char(alpha_lo_q, alpha_hi_q, sirt_pkg::SlotW'(j)) == cur_char)) begin
        char_bad = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    mag_d       = mag_q;
    idx_d       = idx_q;
    ndig_d      = ndig_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    push        = 1'b0;
    pop         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          neg_d  = raw[sirt_pkg::MagW-1];
          mag_d  = raw[sirt_pkg::MagW-1] ? (sirt_pkg::MagW'(0) - raw) : raw;
          idx_d  = '0;
          ndig_d = '0;
          if (len_ok) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (char_bad) begin
          state_d = ST_IDLE;
        end else if (idx_q == last_idx) begin
          state_d = ST_DIV_MUL;
        end else begin
          idx_d = idx_q + sirt_pkg::SlotW'(1);
        end
      end
      ST_DIV_MUL: begin
        state_d = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        push   = 1'b1;
        ndig_d = ndig_q + sirt_pkg::CntW'(1);
        mag_d  = div_rsp.quot;
        if (div_rsp.quot == '0) begin
          sign_pend_d = neg_q;
          state_d     = ST_EMIT;
        end else begin
          state_d = ST_DIV_MUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            out_char_d  = sirt_pkg::CharMinus;
            out_last_d  = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            pop        = 1'b1;
            out_char_d = sirt_pkg::alpha_char(alpha_lo_q, alpha_hi_q,
                                              sirt_pkg::SlotW'(stack_q[0]));
            out_last_d = (ndig_q == sirt_pkg::CntW'(1));
            ndig_d     = ndig_q - sirt_pkg::CntW'(1);
            if (ndig_q == sirt_pkg::CntW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      sign_pend_q <= 1'b0;
      mag_q       <= '0;
      idx_q       <= '0;
      ndig_q      <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      sign_pend_q <= sign_pend_d;
      mag_q       <= mag_d;
      idx_q       <= idx_d;
      ndig_q      <= ndig_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q <= '0;
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sirt_pkg::RegBaseLen:    base_len_q <= cfg_i.data[sirt_pkg::LenW-1:0];
        sirt_pkg::RegAlphabetLo: alpha_lo_q <= cfg_i.data;
        sirt_pkg::RegAlphabetHi: alpha_hi_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= div_rsp.digit;
      for (int k = 1; k < sirt_pkg::StackDepth; k++) begin
        stack_q[k] <= stack_q[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < sirt_pkg::StackDepth - 1; k++) begin
        stack_q[k] <= stack_q[k+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_digit_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_FIX |-> sirt_pkg::LenW'(div_rsp.digit) < base_len_q)
    else $error("digit not below the radix");

  a_emit_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> ndig_q != '0)
    else $error("emitting with an empty digit stack");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_FIX |-> ndig_q < sirt_pkg::CntW'(sirt_pkg::StackDepth))
    else $error("digit stack overflow");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && out_free && !sign_pend_q && (ndig_q == sirt_pkg::CntW'(1))
    |=> out_valid_q && out_last_q && (state_q == ST_IDLE))
    else $error("final character not marked or item not closed");
`endif

endmodule

### sim/signed_int_to_radix_text_top_tb.sv
// Testbench for signed_int_to_radix_text_top: numbers are sent through the input
// channel under several alphabets and handshake patterns, and each character is checked.
// Depends on sirt_pkg, the channel interfaces and the top level RTL.
module signed_int_to_radix_text_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sirt_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(3);
  localparam int unsigned DrainCycles = 160;
  localparam int unsigned HoldLen     = 300;
  localparam int unsigned CycleLimit  = 400000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sirt_in_if  in_if ();
  sirt_out_if out_if ();
  sirt_cfg_if cfg_if ();

  signed_int_to_radix_text_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [LenW-1:0]     cfg_base_len = '0;
  logic [CfgDataW-1:0] cfg_alpha_lo = '0;
  logic [CfgDataW-1:0] cfg_alpha_hi = '0;

  logic [MagW-1:0] numbers_to_send[$];
  text_char_t      pending_text[$];
  text_char_t      want;
  int unsigned     items_total = 0;
  int unsigned     items_taken = 0;
  int unsigned     mismatches  = 0;
  int unsigned     cycle_cnt   = 0;
  logic            value_taken = 1'b0;
  idle_mode_e      idle_mode   = IDLE_NONE;
  logic            hold_req    = 1'b0;
  logic            hold_seen   = 1'b0;
  int unsigned     hold_cnt    = 0;

  function automatic logic [7:0] digit_char(int unsigned pos);
    logic [CfgDataW-1:0] word;
    word = (pos & 8) != 0 ? cfg_alpha_hi : cfg_alpha_lo;
    return 8'(word >> (8 * (pos % 8)));
  endfunction

  function automatic bit alphabet_ok();
    logic [7:0] c;
    if (cfg_base_len < MinBase || cfg_base_len > MaxBase) return 1'b0;
    for (int i = 0; i < int'(cfg_base_len); i++) begin
      c = digit_char(i);
      if (c == CharNul || c == CharMinus || c == CharPlus) return 1'b0;
      for (int j = i + 1; j < int'(cfg_base_len); j++) begin
        if (digit_char(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void render_text(logic [MagW-1:0] raw);
    logic [MagW-1:0] mag;
    logic [MagW-1:0] radix;
    logic [DigW-1:0] dig [MagW];
    int              nd;
    if (!alphabet_ok()) return;
    radix = MagW'(cfg_base_len);
    mag   = raw[MagW-1] ? (MagW'(0) - raw) : raw;
    nd    = 0;
    do begin
      dig[nd] = DigW'(mag % radix);
      nd++;
      mag = mag / radix;
    end while (mag != 0 && nd < MagW);
    if (raw[MagW-1]) pending_text.push_back('{ch: CharMinus, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--) begin
      pending_text.push_back('{ch: digit_char(dig[i]), last: 1'(i == 0)});
    end
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 58;
      IDLE_BOTH: return $urandom_range(0, 99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 58;
      IDLE_BOTH: return $urandom_range(0, 99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic [MagW-1:0] rand_value();
    logic [MagW-1:0] v;
    int unsigned     pick;
    pick = $urandom_range(0, 4);
    if (pick == 1) begin
      v = $urandom_range(0, 40);
      return $urandom_range(0, 1) ? -v : v;
    end else if (pick == 2) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (pick == 3) begin
      v = $urandom >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? -v : v;
    end
    return $urandom;
  endfunction

  function automatic void send(logic [MagW-1:0] v);
    numbers_to_send.push_back(v);
    items_total++;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || value_taken)) begin
      if (numbers_to_send.size() != 0 && !sender_rests()) begin
        in_if.valid <= 1'b1;
        in_if.value <= numbers_to_send.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    value_taken <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) begin
      render_text(in_if.value);
      items_taken++;
    end
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** signed_int_to_radix_text_top: FAILED **");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_cnt  <= HoldLen;
      hold_seen <= hold_req;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= (hold_cnt == 0) && !receiver_stalls();
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_text.size() == 0) begin
        $error("out_char: expected nothing, got 8'h%02h", out_if.out_char);
        mismatches++;
      end else begin
        want = pending_text.pop_front();
        if (out_if.out_char !== want.ch) begin
          $error("out_char: expected 8'h%02h, got 8'h%02h", want.ch, out_if.out_char);
          mismatches++;
        end
        if (out_if.last_char !== want.last) begin
          $error("last_char: expected %b, got %b", want.last, out_if.last_char);
          mismatches++;
        end
      end
    end
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      RegBaseLen:    cfg_base_len = data[LenW-1:0];
      RegAlphabetLo: cfg_alpha_lo = data;
      RegAlphabetHi: cfg_alpha_hi = data;
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_alphabet(input logic [LenW-1:0] n, input logic [CfgDataW-1:0] lo,
                              input logic [CfgDataW-1:0] hi);
    logic [CfgDataW-1:0] word;
    word = {$urandom, $urandom};
    word[LenW-1:0] = n;
    cfg_write(RegBaseLen, word);
    cfg_write(RegAlphabetLo, lo);
    cfg_write(RegAlphabetHi, hi);
    cfg_release();
  endtask

  task automatic drain();
    while (items_taken != items_total || pending_text.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic check_rejected(input logic [LenW-1:0] n, input logic [CfgDataW-1:0] lo,
                                input logic [CfgDataW-1:0] hi, input logic [MagW-1:0] v);
    set_alphabet(n, lo, hi);
    send(v);
    drain();
  endtask

  task automatic pick_alphabet(output logic [LenW-1:0] n, output logic [CfgDataW-1:0] lo,
                               output logic [CfgDataW-1:0] hi);
    logic [7:0]  ch [Slots];
    bit          used [256];
    int unsigned c;
    int unsigned roll;
    int unsigned a;
    int unsigned b;
    for (int i = 0; i < Slots; i++) begin
      do c = $urandom_range(1, 255); while (c == CharMinus || c == CharPlus || used[c]);
      used[c] = 1'b1;
      ch[i]   = 8'(c);
    end
    n    = LenW'($urandom_range(2, 16));
    roll = $urandom_range(0, 9);
    a    = $urandom_range(0, n - 1);
    if (roll == 0) begin
      ch[a] = CharNul;
    end else if (roll == 1) begin
      ch[a] = $urandom_range(0, 1) ? CharMinus : CharPlus;
    end else if (roll == 2) begin
      a     = $urandom_range(0, n - 2);
      b     = $urandom_range(a + 1, n - 1);
      ch[b] = ch[a];
    end else if (roll == 3) begin
      n = LenW'($urandom_range(0, 31));
    end else if (roll == 4 && n < Slots) begin
      ch[$urandom_range(n, Slots - 1)] = $urandom_range(0, 1) ? CharNul : CharMinus;
    end
    for (int i = 0; i < Slots; i++) begin
      if (i < 8) lo[8*i +: 8] = ch[i];
      else       hi[8*(i-8) +: 8] = ch[i];
    end
  endtask

  initial begin
    logic [LenW-1:0]     n;
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_alphabet(5'd10, "76543210", "FEDCBA98");
    send(32'd0);
    send(32'd1);
    send(32'hFFFF_FFFF);
    send(32'h7FFF_FFFF);
    send(32'h8000_0000);
    send(-32'd10);
    send(32'd1234567890);
    drain();

    set_alphabet(5'd16, "76543210", "fedcba98");
    send(32'hDEAD_BEEF);
    send(32'h7FFF_FFFF);
    send(32'h8000_0000);
    drain();

    // Slots past the radix hold characters that would be illegal inside it.
    set_alphabet(5'd2, {CharMinus, CharPlus, CharNul, CharNul, CharNul, CharNul, "10"}, '0);
    send(32'h8000_0000);
    send(32'h7FFF_FFFF);
    send(32'd0);
    drain();

    set_alphabet(5'd3, {40'h0, 8'h01, 8'h80, 8'hFF}, '1);
    send(-32'd5);
    send(32'd100);
    drain();

    // A write to the unused index must leave the base 3 alphabet in place.
    cfg_write(RegUnused, '1);
    cfg_release();
    send(32'd7);
    drain();

    check_rejected(5'd0, "76543210", "FEDCBA98", 32'd5);
    check_rejected(5'd1, "76543210", "FEDCBA98", -32'd5);
    check_rejected(5'd17, "76543210", "FEDCBA98", 32'd42);
    check_rejected(5'd31, "76543210", "FEDCBA98", 32'h8000_0000);
    check_rejected(5'd10, "76543710", "FEDCBA98", 32'd99);
    check_rejected(5'd8, {"76543", CharNul, "10"}, "FEDCBA98", 32'd12);
    check_rejected(5'd8, {"7654", CharMinus, "210"}, "FEDCBA98", -32'd77);
    check_rejected(5'd8, {CharPlus, "6543210"}, "FEDCBA98", 32'd1);

    for (int p = 0; p < 11; p++) begin
      pick_alphabet(n, lo, hi);
      set_alphabet(n, lo, hi);
      idle_mode <= idle_mode_e'(p % 4);
      repeat (7) send(rand_value());
      drain();
    end

    set_alphabet(5'd2, "76543210", "FEDCBA98");
    idle_mode <= IDLE_NONE;
    hold_req  <= ~hold_req;
    repeat (6) send(rand_value());
    drain();

    if (mismatches == 0) begin
      $display("** signed_int_to_radix_text_top: PASSED **");
    end else begin
      $display("** signed_int_to_radix_text_top: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sirt_pkg.sv
rtl/sirt_if.sv
rtl/sirt_div.sv
rtl/signed_int_to_radix_text_top.sv
sim/signed_int_to_radix_text_top_tb.sv
